// ===== rtl/moi_pkg.sv =====
// Shared types, constants and the divide-by-45 digit step for the multistep integrator.
package moi_pkg;

    localparam int VAL_W       = 32;
    localparam int STEP_W      = 24;
    localparam int SUM_W       = 43;
    localparam int PROD_W      = 67;
    localparam int FRAC_SHIFT  = 20;
    localparam int QW          = 52;
    localparam int DIG_W       = 13;
    localparam int DIGITS      = 4;
    localparam int REM_W       = 6;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 25;
    localparam int BIAS_POS    = 46;
    localparam int HIST_W      = 3 * VAL_W;
    localparam int FIFO_DEPTH  = 16;

    localparam logic [STEP_W-1:0]      STEP_RESET    = 24'd65536;
    localparam logic [1:0]             STARTUP_DONE  = 2'd3;
    localparam logic signed [SUM_W-1:0] W_NEW        = 43'sd1148;
    localparam logic signed [SUM_W-1:0] W_R1         = 43'sd515;
    localparam logic signed [SUM_W-1:0] W_R2         = 43'sd106;
    localparam logic signed [SUM_W-1:0] W_R3         = 43'sd19;
    localparam logic signed [SUM_W-1:0] W_EULER      = 43'sd720;
    localparam logic [REM_W-1:0]       DIV_K         = 6'd45;
    localparam logic [RECIP_W-1:0]     DIV_RECIP     = 20'd745655;
    localparam logic [QW-1:0]          DIV_BIAS      = 52'd45 << BIAS_POS;
    localparam logic signed [VAL_W-1:0] VAL_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN      = 32'sh8000_0000;

    typedef struct packed {
        logic [7:0]              cell_index;
        logic [4:0]              species_index;
        logic signed [VAL_W-1:0] current_value;
        logic signed [VAL_W-1:0] rate;
        logic                    last_of_step;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] next_value;
        logic                    saturated;
        logic                    used_euler;
    } out_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] cur;
        logic                    euler;
    } side_t;

    // one long-division digit by 45: {quotient, remainder}
    function automatic logic [DIG_W+REM_W-1:0] div45_step(
        input logic [REM_W+DIG_W-1:0] v
    );
        logic [REM_W+DIG_W+RECIP_W-1:0] prod;
        logic [DIG_W-1:0]               q;
        logic [REM_W+DIG_W-1:0]         back;
        prod = v * DIV_RECIP;
        q    = prod[RECIP_SHIFT +: DIG_W];
        back = v - ({{REM_W{1'b0}}, q} * {{DIG_W{1'b0}}, DIV_K});
        return {q, back[REM_W-1:0]};
    endfunction

endpackage

// ===== rtl/moi_stream_if.sv =====
// Valid/ready stream interface carrying one request or result payload.
interface moi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/multistep_ode_integrator_top.sv =====
// Four-step multistep integrator: history memory, weighted sum, scaling and saturation.
// Structure: 8 pipeline stages from request acceptance to result valid, then the output queue.
// Throughput: one request per cycle below 16 outstanding; one history read and one write-back a cycle, with bypass.
// Up to 16 requests may be outstanding; the 16-entry output queue bounds that figure.
// Reset: step size returns to 1.0, start-up count and all valid state clear at once;
// the history memory is not cleared.
module multistep_ode_integrator_top
    import moi_pkg::*;
#(
    parameter int CELLS   = 256,
    parameter int SPECIES = 32
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_wdata,
    moi_stream_if.sink        operand,
    moi_stream_if.source      result
);

    localparam int PAIRS   = CELLS * SPECIES;
    localparam int AW      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ADDR_FW = 21;
    localparam int STAGES  = 4 + DIGITS;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W   = $clog2(FIFO_DEPTH);

    logic                     acc_in;
    logic                     acc_out;
    logic [CNT_W-1:0]         pend_reg;
    logic [CNT_W-1:0]         pend_next;
    logic [1:0]               startup_reg;
    logic [1:0]               startup_next;
    logic [STEP_W-1:0]        step_reg;

    logic [ADDR_FW-1:0]       addr_full;
    logic [AW-1:0]            addr_in;
    logic                     inr_in;

    logic [STAGES-1:0]        vld_reg;
    side_t                    side_reg [STAGES];

    logic [AW-1:0]            addr0_reg;
    logic                     inr0_reg;
    logic signed [VAL_W-1:0]  rate0_reg;
    logic [HIST_W-1:0]        hist_mem [PAIRS];
    logic [HIST_W-1:0]        rd_reg;
    logic                     fwd_reg;
    logic [HIST_W-1:0]        fwd_data_reg;
    logic [HIST_W-1:0]        hist0;
    logic [HIST_W-1:0]        new_hist;
    logic                     hist_we;

    logic signed [SUM_W-1:0]  x0;
    logic signed [SUM_W-1:0]  x1;
    logic signed [SUM_W-1:0]  x2;
    logic signed [SUM_W-1:0]  x3;
    logic signed [SUM_W-1:0]  sum1_next;
    logic signed [SUM_W-1:0]  sum1_reg;

    logic signed [59:0]       pl2_reg;
    logic signed [51:0]       ph2_reg;

    logic signed [PROD_W-1:0] ph_ext;
    logic signed [PROD_W-1:0] p_full;
    logic signed [QW-1:0]     xq;
    logic [QW-1:0]            y3_reg;

    logic [QW-1:0]            dw_reg [DIGITS];
    logic [REM_W-1:0]         dr_reg [DIGITS];
    logic [QW-1:0]            w_in_c [DIGITS];
    logic [REM_W-1:0]         r_in_c [DIGITS];
    logic [DIG_W+REM_W-1:0]   st_c   [DIGITS];
    logic [QW-1:0]            w_out_c [DIGITS];

    logic signed [48:0]       cur_x;
    logic signed [48:0]       tot;
    logic signed [48:0]       lim_hi;
    logic signed [48:0]       lim_lo;
    out_item_t                fin;

    out_item_t                fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]         wptr_reg;
    logic [PTR_W-1:0]         rptr_reg;
    logic [CNT_W-1:0]         fcnt_reg;
    logic [CNT_W-1:0]         fcnt_next;

    // handshakes and bookkeeping
    assign acc_in        = operand.valid && operand.ready;
    assign acc_out       = result.valid && result.ready;
    assign operand.ready = (pend_reg < CNT_W'(FIFO_DEPTH));
    assign result.valid  = (fcnt_reg != '0);
    assign result.payload = fifo_mem[rptr_reg];

    assign pend_next = pend_reg + CNT_W'(acc_in) - CNT_W'(acc_out);
    assign fcnt_next = fcnt_reg + CNT_W'(vld_reg[STAGES-1]) - CNT_W'(acc_out);

    always_comb
    begin
        startup_next = startup_reg;
        if (acc_in && operand.payload.last_of_step && (startup_reg != STARTUP_DONE))
        begin
            startup_next = startup_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            fcnt_reg    <= '0;
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            startup_reg <= '0;
            step_reg    <= STEP_RESET;
            vld_reg     <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            fcnt_reg    <= fcnt_next;
            startup_reg <= startup_next;
            vld_reg     <= {vld_reg[STAGES-2:0], acc_in};
            fwd_reg     <= acc_in && inr_in && vld_reg[0] && inr0_reg && (addr_in == addr0_reg);
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (vld_reg[STAGES-1])
            begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (acc_out)
            begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
        end
    end

    // stage 0: address, history read
    assign addr_full = ADDR_FW'(operand.payload.cell_index) * ADDR_FW'(SPECIES)
                     + ADDR_FW'(operand.payload.species_index);
    assign addr_in   = addr_full[AW-1:0];
    assign inr_in    = (32'(operand.payload.cell_index) < CELLS)
                    && (32'(operand.payload.species_index) < SPECIES);

    always_ff @(posedge clk)
    begin
        addr0_reg     <= addr_in;
        inr0_reg      <= inr_in;
        rate0_reg     <= operand.payload.rate;
        side_reg[0]   <= '{cur: operand.payload.current_value,
                           euler: (startup_reg != STARTUP_DONE)};
        fwd_data_reg  <= new_hist;
        for (int i = 1; i < STAGES; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[addr0_reg] <= new_hist;
        end
        rd_reg <= hist_mem[addr_in];
    end

    // stage 1: history select with bypass, weighted sum, write-back
    always_comb
    begin
        if (!inr0_reg)
        begin
            hist0 = '0;
        end
        else if (fwd_reg)
        begin
            hist0 = fwd_data_reg;
        end
        else
        begin
            hist0 = rd_reg;
        end
    end

    assign new_hist = {hist0[2*VAL_W-1:0], rate0_reg};
    assign hist_we  = vld_reg[0] && inr0_reg;

    assign x0 = rate0_reg;
    assign x1 = $signed(hist0[VAL_W-1:0]);
    assign x2 = $signed(hist0[2*VAL_W-1:VAL_W]);
    assign x3 = $signed(hist0[3*VAL_W-1:2*VAL_W]);

    // Euler rides the same scaling path: 720*r0 over 720 is r0
    always_comb
    begin
        if (side_reg[0].euler)
        begin
            sum1_next = W_EULER * x0;
        end
        else
        begin
            sum1_next = W_NEW * x0 - W_R1 * x1 + W_R2 * x2 - W_R3 * x3;
        end
    end

    // stage 2: split product by step size
    // stage 3: recombine, drop 2^20, bias positive for the divide by 45
    assign ph_ext = ph2_reg;
    assign p_full = pl2_reg + (ph_ext <<< 16);
    assign xq     = $signed(p_full[PROD_W-1:FRAC_SHIFT]);

    always_ff @(posedge clk)
    begin
        sum1_reg <= sum1_next;
        pl2_reg  <= sum1_reg * $signed({1'b0, step_reg[15:0]});
        ph2_reg  <= sum1_reg * $signed({1'b0, step_reg[STEP_W-1:16]});
        y3_reg   <= xq + DIV_BIAS;
    end

    // stages 4..7: long division by 45, one 13-bit digit a stage
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            w_in_c[k] = (k == 0) ? y3_reg : dw_reg[(k == 0) ? 0 : k-1];
            r_in_c[k] = (k == 0) ? '0 : dr_reg[(k == 0) ? 0 : k-1];
            st_c[k]   = div45_step({r_in_c[k], w_in_c[k][QW-1-k*DIG_W -: DIG_W]});
            w_out_c[k] = w_in_c[k];
            w_out_c[k][QW-1-k*DIG_W -: DIG_W] = st_c[k][REM_W +: DIG_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            dw_reg[k] <= w_out_c[k];
            dr_reg[k] <= st_c[k][REM_W-1:0];
        end
    end

    // final add, unbias and clamp
    assign cur_x  = side_reg[STAGES-1].cur;
    assign lim_hi = VAL_MAX;
    assign lim_lo = VAL_MIN;
    assign tot    = $signed({2'b00, dw_reg[DIGITS-1][BIAS_POS:0]})
                  - (49'sd1 <<< BIAS_POS) + cur_x;

    always_comb
    begin
        fin.used_euler = side_reg[STAGES-1].euler;
        if (tot > lim_hi)
        begin
            fin.next_value = VAL_MAX;
            fin.saturated  = 1'b1;
        end
        else if (tot < lim_lo)
        begin
            fin.next_value = VAL_MIN;
            fin.saturated  = 1'b1;
        end
        else
        begin
            fin.next_value = tot[VAL_W-1:0];
            fin.saturated  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[STAGES-1])
        begin
            fifo_mem[wptr_reg] <= fin;
        end
    end

endmodule

// ===== rtl/moi_checker.sv =====
// Port-level checks on the multistep integrator, bound to its top level.
module moi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        op_valid,
    input logic        op_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] next_value,
    input logic        saturated,
    input logic        used_euler
);

    logic [5:0] pend_reg;
    logic [5:0] pend_next;
    logic       seen_ms_reg;

    assign pend_next = pend_reg + 6'(op_valid && op_ready) - 6'(res_valid && res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            seen_ms_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (res_valid && res_ready && !used_euler)
            begin
                seen_ms_reg <= 1'b1;
            end
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(next_value)
            && $stable(saturated) && $stable(used_euler))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pend_reg != 6'd0)
        else $error("result without an outstanding request");

    a_startup_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_ms_reg |-> !used_euler)
        else $error("Euler result after a multistep result");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && saturated |-> next_value == 32'h7FFF_FFFF || next_value == 32'h8000_0000)
        else $error("saturated flag without a clamped value");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight out of reset");

endmodule

bind multistep_ode_integrator_top moi_checker u_moi_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (operand.valid),
    .op_ready   (operand.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .next_value (result.payload.next_value),
    .saturated  (result.payload.saturated),
    .used_euler (result.payload.used_euler)
);
